// File: rtl/core/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared types and constants for the Gaussian blur tap generator.
// ----------------------------------------------------------------------------
`default_nettype none
package gbt_pkg;

  localparam int SIDE_TAPS_DEF = 8;
  localparam int MDU_W         = 64;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int OFS_W         = 25;
  localparam int WGT_W         = 17;
  localparam int DIR_W         = 16;
  localparam int SIZE_W        = 14;

  localparam logic [15:0] SIGMA_RST  = 16'd256;
  localparam logic [13:0] WIDTH_RST  = 14'd1280;
  localparam logic [13:0] HEIGHT_RST = 14'd720;

  localparam logic [MDU_W-1:0] Q32_ONE    = 64'h1_0000_0000;
  localparam logic [MDU_W-1:0] Q32_HALF   = 64'h8000_0000;
  localparam logic [MDU_W-1:0] EXP_CUTOFF = 64'd23 << 16;
  localparam logic [3:0]       TAYLOR_N   = 4'd10;
  localparam logic [2:0]       SQUARE_N   = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/gaussian_blur_tap_generator.sv
// ----------------------------------------------------------------------------
// gaussian_blur_tap_generator
// Separable Gaussian blur taps: offsets and normalised weights per direction.
//
//   channel | signals                                       | handshake
//   request | dir_x, dir_y                                  | req_valid / req_stall
//   tap     | tap_index, offset_x, offset_y, weight, last_tap | tap_valid / tap_stall
//   config  | cfg_index, cfg_data                           | cfg_we
//
// Every multiply and divide runs on one bit-serial unit;
// Taylor divides by the term number are reciprocal multiplies.
// A request issues fewer unit operations when a tap's exponent cuts off.
// req_stall stays high from acceptance until the last tap is loaded.
// Synchronous reset restores the register defaults; a stalled tap holds.
// ----------------------------------------------------------------------------
`default_nettype none
module gaussian_blur_tap_generator #(
  parameter int SIDE_TAPS = gbt_pkg::SIDE_TAPS_DEF,
  localparam int TAP_IDX_W = $clog2(2 * SIDE_TAPS - 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [gbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gbt_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic signed [gbt_pkg::DIR_W-1:0]  dir_x,
  input  wire logic signed [gbt_pkg::DIR_W-1:0]  dir_y,
  output logic                                   tap_valid,
  input  wire logic                              tap_stall,
  output logic [TAP_IDX_W-1:0]                   tap_index,
  output logic signed [gbt_pkg::OFS_W-1:0]       offset_x,
  output logic signed [gbt_pkg::OFS_W-1:0]       offset_y,
  output logic [gbt_pkg::WGT_W-1:0]              weight,
  output logic                                   last_tap
);

  localparam int W    = gbt_pkg::MDU_W;
  localparam int OW   = gbt_pkg::OFS_W;
  localparam int KW   = $clog2(SIDE_TAPS);
  localparam int KKW  = $clog2((SIDE_TAPS - 1) * (SIDE_TAPS - 1) + 1);
  localparam int LAST = 2 * SIDE_TAPS - 2;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_WAIT  = 19'h00002,
    S_D2A   = 19'h00004,
    S_D2B   = 19'h00008,
    S_DEN   = 19'h00010,
    S_TAPA  = 19'h00020,
    S_ARG   = 19'h00040,
    S_EXPC  = 19'h00080,
    S_TDIV  = 19'h00100,
    S_TSUM  = 19'h00200,
    S_SQ    = 19'h00400,
    S_SQR   = 19'h00800,
    S_OFSX  = 19'h01000,
    S_OFSXD = 19'h02000,
    S_OFSXR = 19'h04000,
    S_OFSYD = 19'h08000,
    S_OFSYR = 19'h10000,
    S_WGT   = 19'h20000,
    S_EMIT  = 19'h40000
  } state_t;

  function automatic logic [OW-1:0] sat_ofs(input logic neg, input logic [W-1:0] q);
    logic [OW-1:0] r;
    if (!neg) r = (q > W'({1'b0, {(OW-1){1'b1}}})) ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
    else r = (q > W'({1'b1, {(OW-1){1'b0}}})) ? {1'b1, {(OW-1){1'b0}}} : OW'(-q[OW-1:0]);
    return r;
  endfunction

  function automatic logic [OW-1:0] neg_sat(input logic [OW-1:0] x);
    logic [OW-1:0] r;
    r = (x == {1'b1, {(OW-1){1'b0}}}) ? {1'b0, {(OW-1){1'b1}}} : OW'(-x);
    return r;
  endfunction

  // ceil(2^36 / d): exact floor division of a 32-bit term after a 36-bit shift
  function automatic logic [W-1:0] recip(input logic [3:0] d);
    logic [W-1:0] r;
    case (d)
      4'd1:    r = 64'd68719476736;
      4'd2:    r = 64'd34359738368;
      4'd3:    r = 64'd22906492246;
      4'd4:    r = 64'd17179869184;
      4'd5:    r = 64'd13743895348;
      4'd6:    r = 64'd11453246123;
      4'd7:    r = 64'd9817068106;
      4'd8:    r = 64'd8589934592;
      4'd9:    r = 64'd7635497416;
      4'd10:   r = 64'd6871947674;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [15:0]            blur_sigma;
  logic [13:0]            image_width;
  logic [13:0]            image_height;

  state_t                 state;
  state_t                 ret;
  gbt_pkg::mdu_ctl_t      ctl;
  logic [W-1:0]           opa;
  logic [W-1:0]           opb;
  logic                   done;
  logic [2*W-1:0]         prod;
  logic [W-1:0]           quo;
  logic [W-1:0]           tdq;

  logic [16:0]            ax;
  logic [16:0]            ay;
  logic                   nx;
  logic                   ny;
  logic [W-1:0]           d2;
  logic [W-1:0]           den;
  logic [W-1:0]           tval;
  logic [W-1:0]           sum;
  logic [W-1:0]           total;
  logic [3:0]             n;
  logic [2:0]             sq;
  logic [KW-1:0]          k;
  logic [KKW-1:0]         kk;
  logic [TAP_IDX_W-1:0]   tap;
  logic [32:0]            raw [SIDE_TAPS];
  logic [OW-1:0]          ox  [SIDE_TAPS];
  logic [OW-1:0]          oy  [SIDE_TAPS];
  logic [KW-1:0]          src;
  logic [15:0]            sig;
  logic [13:0]            wid;
  logic [13:0]            hgt;

  assign quo = prod[W-1:0];
  assign tdq = prod[W+35:36];
  assign sig = (blur_sigma == 16'd0) ? 16'd1 : blur_sigma;
  assign wid = (image_width == 14'd0) ? 14'd1 : image_width;
  assign hgt = (image_height == 14'd0) ? 14'd1 : image_height;
  assign src = (tap < TAP_IDX_W'(SIDE_TAPS)) ? KW'(tap)
                                             : KW'(tap - TAP_IDX_W'(SIDE_TAPS - 1));
  assign req_stall = (state != S_IDLE);

  gbt_muldiv u_mdu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .opa    (opa),
    .opb    (opb),
    .done   (done),
    .result (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_sigma   <= gbt_pkg::SIGMA_RST;
      image_width  <= gbt_pkg::WIDTH_RST;
      image_height <= gbt_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbt_pkg::CFG_SIGMA:  blur_sigma   <= cfg_data;
        gbt_pkg::CFG_WIDTH:  image_width  <= cfg_data[13:0];
        gbt_pkg::CFG_HEIGHT: image_height <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      ctl       <= '{start: 1'b0, op: gbt_pkg::MDU_MUL};
      tap_valid <= 1'b0;
    end else begin
      if (tap_valid && !tap_stall && state != S_EMIT) tap_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            nx <= dir_x[15];
            ny <= dir_y[15];
            ax <= dir_x[15] ? 17'(-{dir_x[15], dir_x}) : {1'b0, dir_x};
            ay <= dir_y[15] ? 17'(-{dir_y[15], dir_y}) : {1'b0, dir_y};
            ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
            opa <= W'(dir_x[15] ? 17'(-{dir_x[15], dir_x}) : {1'b0, dir_x});
            opb <= W'(dir_x[15] ? 17'(-{dir_x[15], dir_x}) : {1'b0, dir_x});
            ret <= S_D2A;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          ctl.start <= 1'b0;
          if (done) state <= ret;
        end
        S_D2A: begin
          d2  <= quo;
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
          opa <= W'(ay);
          opb <= W'(ay);
          ret <= S_D2B;
          state <= S_WAIT;
        end
        S_D2B: begin
          d2  <= d2 + quo;
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
          opa <= W'(sig);
          opb <= W'(sig);
          ret <= S_DEN;
          state <= S_WAIT;
        end
        S_DEN: begin
          den    <= quo << 1;
          total  <= gbt_pkg::Q32_ONE;
          raw[0] <= 33'(gbt_pkg::Q32_ONE);
          ox[0]  <= '0;
          oy[0]  <= '0;
          k      <= KW'(1);
          kk     <= KKW'(1);
          state  <= S_TAPA;
        end
        S_TAPA: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
          opa <= W'(kk);
          opb <= d2;
          ret <= S_ARG;
          state <= S_WAIT;
        end
        S_ARG: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_DIV};
          opa <= quo << 16;
          opb <= den;
          ret <= S_EXPC;
          state <= S_WAIT;
        end
        S_EXPC: begin
          if (quo >= gbt_pkg::EXP_CUTOFF) begin
            sum   <= '0;
            sq    <= gbt_pkg::SQUARE_N;
            state <= S_SQ;
          end else begin
            tval <= quo << 11;
            sum  <= gbt_pkg::Q32_ONE;
            n    <= 4'd1;
            ctl  <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
            opa  <= gbt_pkg::Q32_ONE;
            opb  <= quo << 11;
            ret  <= S_TDIV;
            state <= S_WAIT;
          end
        end
        S_TDIV: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
          opa <= W'(prod[W-1:32]);
          opb <= recip(n);
          ret <= S_TSUM;
          state <= S_WAIT;
        end
        S_TSUM: begin
          if (n == gbt_pkg::TAYLOR_N) begin
            sum   <= (sum + tdq > gbt_pkg::Q32_ONE) ? gbt_pkg::Q32_ONE : sum + tdq;
            sq    <= '0;
            state <= S_SQ;
          end else begin
            if (n[0]) sum <= (sum >= tdq) ? sum - tdq : '0;
            else sum <= sum + tdq;
            n   <= n + 4'd1;
            ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
            opa <= tdq;
            opb <= tval;
            ret <= S_TDIV;
            state <= S_WAIT;
          end
        end
        S_SQ: begin
          if (sq == gbt_pkg::SQUARE_N) begin
            raw[k] <= sum[32:0];
            total  <= total + (sum << 1);
            state  <= S_OFSX;
          end else if (sum < gbt_pkg::Q32_ONE) begin
            ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
            opa <= sum;
            opb <= sum;
            ret <= S_SQR;
            state <= S_WAIT;
          end else begin
            sq <= sq + 3'd1;
          end
        end
        S_SQR: begin
          sum   <= W'((prod + (2*W)'(gbt_pkg::Q32_HALF)) >> 32);
          sq    <= sq + 3'd1;
          state <= S_SQ;
        end
        S_OFSX: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
          opa <= W'(ax);
          opb <= W'({k, 8'd0});
          ret <= S_OFSXD;
          state <= S_WAIT;
        end
        S_OFSXD: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_DIV};
          opa <= (quo << 1) + W'(wid);
          opb <= W'({wid, 1'b0});
          ret <= S_OFSXR;
          state <= S_WAIT;
        end
        S_OFSXR: begin
          ox[k] <= sat_ofs(nx, quo);
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_MUL};
          opa <= W'(ay);
          opb <= W'({k, 8'd0});
          ret <= S_OFSYD;
          state <= S_WAIT;
        end
        S_OFSYD: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_DIV};
          opa <= (quo << 1) + W'(hgt);
          opb <= W'({hgt, 1'b0});
          ret <= S_OFSYR;
          state <= S_WAIT;
        end
        S_OFSYR: begin
          oy[k] <= sat_ofs(ny, quo);
          if (k == KW'(SIDE_TAPS - 1)) begin
            tap   <= '0;
            state <= S_WGT;
          end else begin
            k     <= k + 1'b1;
            kk    <= KKW'(32'(kk) + 32'({k, 1'b1}));
            state <= S_TAPA;
          end
        end
        S_WGT: begin
          ctl <= '{start: 1'b1, op: gbt_pkg::MDU_DIV};
          opa <= (W'(raw[src]) << 16) + (total >> 1);
          opb <= total;
          ret <= S_EMIT;
          state <= S_WAIT;
        end
        S_EMIT: begin
          if (!tap_valid || !tap_stall) begin
            tap_valid <= 1'b1;
            tap_index <= tap;
            weight    <= quo[gbt_pkg::WGT_W-1:0];
            last_tap  <= (tap == TAP_IDX_W'(LAST));
            if (tap < TAP_IDX_W'(SIDE_TAPS)) begin
              offset_x <= ox[src];
              offset_y <= oy[src];
            end else begin
              offset_x <= neg_sat(ox[src]);
              offset_y <= neg_sat(oy[src]);
            end
            if (tap == TAP_IDX_W'(LAST)) begin
              state <= S_IDLE;
            end else begin
              tap   <= tap + 1'b1;
              state <= S_WGT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gbt_muldiv.sv
// ----------------------------------------------------------------------------
// gbt_muldiv
// Shared bit-serial unit: 64x64 shift-add multiply (128-bit product) or
// 64/64 restoring divide (quotient in the low half), one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gbt_muldiv (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gbt_pkg::mdu_ctl_t             ctl,
  input  wire logic [gbt_pkg::MDU_W-1:0]     opa,
  input  wire logic [gbt_pkg::MDU_W-1:0]     opb,
  output logic                               done,
  output logic [2*gbt_pkg::MDU_W-1:0]        result
);

  localparam int W  = gbt_pkg::MDU_W;
  localparam int CW = $clog2(W + 1);

  logic                busy;
  gbt_pkg::mdu_op_t    op;
  logic [CW-1:0]       cnt;
  logic [W-1:0]        mcand;
  logic [W-1:0]        shf;
  logic [W-1:0]        rem;
  logic [2*W-1:0]      acc;
  logic [W:0]          psum;
  logic [W:0]          trial;
  logic [W:0]          tdiff;

  assign psum  = {1'b0, acc[2*W-1:W]} + (shf[0] ? {1'b0, mcand} : '0);
  assign trial = {rem, shf[W-1]};
  assign tdiff = trial - {1'b0, mcand};
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      op    <= ctl.op;
      cnt   <= CW'(W);
      mcand <= opb;
      shf   <= opa;
      rem   <= '0;
      acc   <= '0;
    end else if (busy) begin
      if (op == gbt_pkg::MDU_MUL) begin
        acc <= {psum, acc[W-1:1]};
        shf <= shf >> 1;
      end else begin
        if (!tdiff[W]) begin
          rem <= tdiff[W-1:0];
          acc <= {acc[2*W-1:W], acc[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          acc <= {acc[2*W-1:W], acc[W-2:0], 1'b0};
        end
        shf <= shf << 1;
      end
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire
